[design/lzw_pkg.sv]
// ----------------------------------------------------------------------------
// lzw_pkg: shared types and constants for the LZ77 window encoder
// Word formats on both channels, the controller states and the control
// bundle that drives the row of history/compare cells.
// ----------------------------------------------------------------------------
package lzw_pkg;

    // Default search window depth in bytes
    localparam int WINDOW_DEF = 10;

    // Input word: one raw byte plus end-of-stream mark
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    // Output word: one (offset, length, next byte) token
    typedef struct packed {
        logic [3:0] match_offset;
        logic [3:0] match_length;
        logic [7:0] next_byte;
        logic       next_is_end;
        logic       token_last;
    } t_out_word;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SEARCH
    } t_state;

    // Control bundle broadcast to every cell
    typedef struct packed {
        logic load;   // copy history byte into compare register, arm match flag
        logic step;   // compare against head byte, shift compare and history
    } t_cell_ctl;

endpackage

[design/lzw_cell.sv]
// ----------------------------------------------------------------------------
// lzw_cell: one window position of the LZ77 encoder
// Holds one history byte and one compare byte. During a search the compare
// bytes slide one place toward the oldest end per cycle while step is set,
// so the cell that started at position p sees history[p+k] on step k and
// keeps a match flag for a candidate starting at p.
// ----------------------------------------------------------------------------
module lzw_cell
    import lzw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  logic       i_hist_vld,     // this position holds a valid history byte
    input  logic [7:0] i_hist_in,      // history byte from the newer neighbor
    input  logic [7:0] i_cmp_in,       // compare byte from the newer neighbor
    input  logic       i_cmp_vld_in,
    input  logic [7:0] i_head,         // lookahead byte under test
    output logic [7:0] o_hist,
    output logic [7:0] o_cmp,
    output logic       o_cmp_vld,
    output logic       o_hit
);

    logic [7:0] r_hist;
    logic [7:0] r_cmp;
    logic       r_cmp_vld;
    logic       r_alive;

    // Candidate still matches after this step
    assign o_hit     = r_alive & r_cmp_vld & (r_cmp == i_head);
    assign o_hist    = r_hist;
    assign o_cmp     = r_cmp;
    assign o_cmp_vld = r_cmp_vld;

    // History byte shifts in from the newer side on every coded byte
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_hist <= i_hist_in;
        end
    end

    // Compare byte: snapshot at load, then slide along the row
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmp <= r_hist;
        end else if (i_ctl.step) begin
            r_cmp <= i_cmp_in;
        end
    end

    // Match tracking flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_alive   <= 1'b0;
        end else if (i_ctl.load) begin
            r_cmp_vld <= i_hist_vld;
            r_alive   <= i_hist_vld;
        end else if (i_ctl.step) begin
            r_cmp_vld <= i_cmp_vld_in;
            r_alive   <= o_hit;
        end
    end

endmodule

[design/lz77_window_encoder_top.sv]
// ----------------------------------------------------------------------------
// lz77_window_encoder_top: streaming LZ77 encoder over a sliding window
// Buffers up to WINDOW+1 raw bytes and emits (offset, length, next byte)
// tokens found by a row of WINDOW compare cells, longest and oldest first.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall | i_in_word  (t_in_word)
//   out     | output    | o_out_valid/ i_out_stall| o_out_word (t_out_word)
//
// A byte forming no token only enters the lookahead. A byte forming a token
// is accepted, loaded, then takes length+1 search steps (length for a match
// that ends the stream); each step consumes one lookahead byte through the
// cell row. The final byte repeats load and search until the lookahead is
// empty. Input is stalled outside the idle state. Reset is synchronous,
// active low, and clears the fill counts; window and lookahead contents are
// not cleared. A stalled output register holds the search on its last step.
// ----------------------------------------------------------------------------
module lz77_window_encoder_top
    import lzw_pkg::*;
#(
    parameter int W = WINDOW_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int LOOK_D = W + 1;
    localparam int LIW    = $clog2(LOOK_D);
    localparam int LFW    = $clog2(LOOK_D + 1);
    localparam int CNTW   = $clog2(W + 1);
    localparam int IDXW   = (W > 1) ? $clog2(W) : 1;

    t_state          r_state, n_state;
    logic [7:0]      r_look [LOOK_D];
    logic [LFW-1:0]  r_lfill;
    logic [CNTW-1:0] r_hfill;
    logic            r_flush;
    logic [CNTW-1:0] r_len;
    logic [CNTW-1:0] r_off;
    t_out_word       r_out, n_out;
    logic            r_out_vld;

    t_cell_ctl       w_ctl;
    logic [7:0]      w_hist [W];
    logic [7:0]      w_cmp  [W];
    logic [W-1:0]    w_cmp_vld;
    logic [W-1:0]    w_hit;
    logic [W-1:0]    w_hv;

    logic            accept;
    logic            any_hit;
    logic [IDXW-1:0] first_hit;
    logic [7:0]      head;
    logic            finish;
    logic            out_free;
    logic            step_go;
    logic            out_load;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;
    assign head        = r_look[0];

    // Row of window cells, oldest at index 0, newest at W-1
    for (genvar p = 0; p < W; p++) begin : g_cell
        logic [7:0] hist_in;
        logic [7:0] cmp_in;
        logic       cmp_vld_in;

        if (p == W - 1) begin : g_end
            assign hist_in    = head;
            assign cmp_in     = 8'h00;
            assign cmp_vld_in = 1'b0;
        end else begin : g_mid
            assign hist_in    = w_hist[p+1];
            assign cmp_in     = w_cmp[p+1];
            assign cmp_vld_in = w_cmp_vld[p+1];
        end

        // Position holds history once the fill reaches back to it
        assign w_hv[p] = ((p + int'(r_hfill)) >= W);

        lzw_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_hist_vld   (w_hv[p]),
            .i_hist_in    (hist_in),
            .i_cmp_in     (cmp_in),
            .i_cmp_vld_in (cmp_vld_in),
            .i_head       (head),
            .o_hist       (w_hist[p]),
            .o_cmp        (w_cmp[p]),
            .o_cmp_vld    (w_cmp_vld[p]),
            .o_hit        (w_hit[p])
        );
    end

    // Oldest surviving candidate
    always_comb begin
        first_hit = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                first_hit = IDXW'(i);
            end
        end
        any_hit = |w_hit;
    end

    // Controller: next state, cell control, token word
    always_comb begin
        n_state  = r_state;
        w_ctl    = '0;
        finish   = ~any_hit | (r_lfill == LFW'(1));
        out_free = ~r_out_vld | ~i_out_stall;
        step_go  = 1'b0;
        out_load = 1'b0;

        n_out.match_offset = any_hit ? 4'(W - int'(first_hit)) : 4'(r_off);
        n_out.match_length = any_hit ? 4'(r_len + CNTW'(1)) : 4'(r_len);
        n_out.next_byte    = any_hit ? 8'h00 : head;
        n_out.next_is_end  = any_hit;
        n_out.token_last   = r_flush & (r_lfill == LFW'(1));

        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_in_word.in_last || (r_lfill == LFW'(W)))) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                w_ctl.load = 1'b1;
                n_state    = S_SEARCH;
            end
            S_SEARCH: begin
                step_go    = ~finish | out_free;
                out_load   = step_go & finish;
                w_ctl.step = step_go;
                if (out_load) begin
                    n_state = (r_flush && (r_lfill != LFW'(1))) ? S_LOAD : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Lookahead buffer: write at fill, shift out from head on each step
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_look[r_lfill[LIW-1:0]] <= i_in_word.in_byte;
        end else if (step_go) begin
            for (int i = 0; i < LOOK_D - 1; i++) begin
                r_look[i] <= r_look[i+1];
            end
        end
    end

    // Fill counts and end-of-stream flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfill <= '0;
            r_hfill <= '0;
            r_flush <= 1'b0;
        end else if (accept) begin
            r_lfill <= r_lfill + LFW'(1);
            r_flush <= i_in_word.in_last;
        end else if (step_go) begin
            r_lfill <= r_lfill - LFW'(1);
            if (out_load && n_out.token_last) begin
                r_hfill <= '0;
                r_flush <= 1'b0;
            end else if (r_hfill != CNTW'(W)) begin
                r_hfill <= r_hfill + CNTW'(1);
            end
        end
    end

    // Running match length and offset of the current token
    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_len <= '0;
            r_off <= '0;
        end else if (step_go && any_hit) begin
            r_len <= r_len + CNTW'(1);
            r_off <= CNTW'(W - int'(first_hit));
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // A search never starts or runs on an empty lookahead
    a_search_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD || r_state == S_SEARCH) |-> (r_lfill != '0))
        else $error("search with empty lookahead");

    // History fill never passes the window depth
    a_hfill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_hfill) <= W)
        else $error("history fill out of range");

    // Final token leaves an empty, idle encoder
    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_out.token_last) |=>
            (r_state == S_IDLE && r_hfill == '0 && r_lfill == '0 && !r_flush))
        else $error("stream end did not clear state");

    // A token is never written over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |-> !out_load)
        else $error("output word overwritten");

    // Lookahead full only right after a byte that forms a token
    a_look_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lfill == LFW'(LOOK_D)) |-> (r_state == S_LOAD || r_state == S_SEARCH))
        else $error("full lookahead while idle");

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lz77_window_encoder_top
// Streams of raw bytes go in through a queued driver, and a predictor
// mirrors the encoder's window and lookahead to form the expected tokens.
// A monitor compares every token field by field. Idling and stalling run
// in four phases, and a watchdog ends a run that hangs.
// ----------------------------------------------------------------------------
module testbench;
    import lzw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN         = WINDOW_DEF;
    localparam int AHEAD_DEPTH = WINDOW_DEF + 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;
    localparam int ITEM_GOAL   = 220;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_word  in_word    = '0;
    logic      out_stall  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    // words waiting for the driver, tokens waiting for the monitor
    t_in_word  bytes_queued[$];
    t_out_word tokens_due[$];
    int unsigned bytes_total;
    int unsigned bytes_taken  = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;

    // predictor copy of the encoder state
    logic [7:0]  win_bytes[WIN];
    int unsigned win_fill   = 0;
    logic [7:0]  ahead_bytes[AHEAD_DEPTH];
    int unsigned ahead_fill = 0;

    wire in_fire  = in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !out_stall;

    lz77_window_encoder_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    // clock and single reset pulse
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_mismatch(string msg);
        if (mismatches < 100)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // ---- predictor ----------------------------------------------------------

    function automatic void window_push(logic [7:0] b);
        int unsigned k;
        if (win_fill < WIN) begin
            win_bytes[win_fill] = b;
            win_fill++;
        end else begin
            for (k = 0; k < WIN - 1; k++)
                win_bytes[k] = win_bytes[k + 1];
            win_bytes[WIN - 1] = b;
        end
    endfunction

    // append one expected token for the monitor
    function automatic void queue_token(t_out_word tok);
        tokens_due.insert(tokens_due.size(), tok);
    endfunction

    // longest prefix inside the window, oldest start on a tie
    function automatic t_out_word form_token();
        t_out_word   tok;
        int unsigned limit, run, s, k, best_len, best_off, used;
        bit          hit;
        tok      = '0;
        best_len = 0;
        best_off = 0;
        limit    = (win_fill < ahead_fill) ? win_fill : ahead_fill;
        for (run = limit; run > 0 && best_len == 0; run--) begin
            for (s = 0; s + run <= win_fill && best_len == 0; s++) begin
                hit = 1'b1;
                for (k = 0; k < run; k++)
                    if (win_bytes[s + k] != ahead_bytes[k]) hit = 1'b0;
                if (hit) begin
                    best_len = run;
                    best_off = win_fill - s;
                end
            end
        end
        if (best_len < ahead_fill) begin
            tok.next_byte = ahead_bytes[best_len];
            used = best_len + 1;
        end else begin
            // match ran into the end of the stream
            tok.next_is_end = 1'b1;
            used = best_len;
        end
        for (k = 0; k < used; k++)
            window_push(ahead_bytes[k]);
        for (k = 0; k + used < ahead_fill; k++)
            ahead_bytes[k] = ahead_bytes[k + used];
        ahead_fill       -= used;
        tok.match_offset = 4'(best_off);
        tok.match_length = 4'(best_len);
        return tok;
    endfunction

    function automatic void encode_byte(t_in_word w);
        t_out_word tok;
        if (ahead_fill < AHEAD_DEPTH) begin
            ahead_bytes[ahead_fill] = w.in_byte;
            ahead_fill++;
        end
        if (!w.in_last) begin
            if (ahead_fill >= AHEAD_DEPTH)
                queue_token(form_token());
        end else begin
            // flush the lookahead, then start a fresh stream
            while (ahead_fill > 0) begin
                tok            = form_token();
                tok.token_last = (ahead_fill == 0);
                queue_token(tok);
            end
            win_fill   = 0;
            ahead_fill = 0;
        end
    endfunction

    // ---- stimulus -----------------------------------------------------------

    function automatic void queue_word(logic [7:0] b, logic last);
        t_in_word w;
        w.in_byte = b;
        w.in_last = last;
        bytes_queued.insert(bytes_queued.size(), w);
    endfunction

    // narrow streams draw from a few symbols so that matches are common
    function automatic void queue_stream(int unsigned len, bit narrow);
        logic [7:0]  alphabet[4];
        int unsigned kinds, n;
        kinds = $urandom_range(4, 1);
        for (n = 0; n < 4; n++)
            alphabet[n] = 8'($urandom);
        for (n = 0; n < len; n++)
            queue_word(narrow ? alphabet[$urandom_range(kinds - 1, 0)] : 8'($urandom),
                       n == len - 1);
    endfunction

    // phase 0 no idling, 1 sender idle, 2 receiver stalls, 3 both
    function automatic int unsigned idle_phase();
        return (bytes_taken * 4) / (bytes_total == 0 ? 1 : bytes_total);
    endfunction

    initial begin
        int unsigned n, pick, len;
        // single-byte stream, top byte value
        queue_word(8'hFF, 1'b1);
        // a run of zeros: steady-state token, then long matches on flush
        for (n = 0; n < 12; n++)
            queue_word(8'h00, n == 11);
        // alternating pattern whose last match reaches the end
        for (n = 0; n < 6; n++)
            queue_word(n[0] ? 8'h55 : 8'hAA, n == 5);
        // short stream of literals on mixed bit patterns
        queue_word(8'h80, 1'b0);
        queue_word(8'h01, 1'b0);
        queue_word(8'h7F, 1'b1);

        while (bytes_queued.size() < ITEM_GOAL) begin
            pick = $urandom_range(99, 0);
            if (pick < 10)      len = $urandom_range(3, 1);
            else if (pick < 30) len = $urandom_range(40, 25);
            else                len = $urandom_range(24, 4);
            queue_stream(len, $urandom_range(99, 0) < 75);
        end
        bytes_total = bytes_queued.size();

        // wait for the last word to go in and every token to come out
        @(posedge i_clk);
        while (bytes_queued.size() != 0 || in_valid || tokens_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ---- driver -------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid)
                encode_byte(in_word);
            if (bytes_queued.size() != 0 &&
                !((idle_phase() == 1 && $urandom_range(99, 0) < 67) ||
                  (idle_phase() == 3 && $urandom_range(99, 0) < 36))) begin
                in_word  <= bytes_queued.pop_front();
                in_valid <= 1'b1;
                bytes_taken++;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---- receiver stall and monitor ----------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_stall <= 1'b0;
        else if (idle_phase() == 2)
            out_stall <= $urandom_range(99, 0) < 67;
        else if (idle_phase() >= 3)
            out_stall <= $urandom_range(99, 0) < 36;
        else
            out_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_fire) begin
            if (tokens_due.size() == 0) begin
                report_mismatch($sformatf(
                    "unexpected token off=%0d len=%0d nb=%02h end=%0b last=%0b",
                    o_out_word.match_offset, o_out_word.match_length,
                    o_out_word.next_byte, o_out_word.next_is_end, o_out_word.token_last));
            end else begin
                want = tokens_due.pop_front();
                if (o_out_word.match_offset != want.match_offset)
                    report_mismatch($sformatf("match_offset got %0d want %0d",
                        o_out_word.match_offset, want.match_offset));
                if (o_out_word.match_length != want.match_length)
                    report_mismatch($sformatf("match_length got %0d want %0d",
                        o_out_word.match_length, want.match_length));
                if (o_out_word.next_byte != want.next_byte)
                    report_mismatch($sformatf("next_byte got %02h want %02h",
                        o_out_word.next_byte, want.next_byte));
                if (o_out_word.next_is_end != want.next_is_end)
                    report_mismatch($sformatf("next_is_end got %0b want %0b",
                        o_out_word.next_is_end, want.next_is_end));
                if (o_out_word.token_last != want.token_last)
                    report_mismatch($sformatf("token_last got %0b want %0b",
                        o_out_word.token_last, want.token_last));
            end
        end
    end

    // ---- watchdog: too long without any word moving ------------------------

    always @(posedge i_clk) begin
        if (in_fire || out_fire)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

[filelist.f]
design/lzw_pkg.sv
design/lzw_cell.sv
design/lz77_window_encoder_top.sv
verif/testbench.sv
